@@ design/rna_pkg.sv @@
package rna_pkg;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_MUL = 3'd2,
    FN_DIV = 3'd3,
    FN_CMP = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ORD_LESS = 2'd0,
    ORD_EQ   = 2'd1,
    ORD_GT   = 2'd2
  } order_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_CHK,
    OP_DISP,
    OP_CHKDIV,
    OP_JMP,
    OP_OUT,
    OP_GCD,
    OP_DIV,
    OP_MUL,
    OP_FIXA,
    OP_FIXB,
    OP_NEGB,
    OP_SWAPB,
    OP_COMB,
    OP_XSIGN,
    OP_RES
  } op_e;

  typedef enum logic [2:0] {
    RS_AN,
    RS_AD,
    RS_BN,
    RS_BD,
    RS_T,
    RS_G
  } rsel_e;

  typedef enum logic [1:0] {
    RK_NONE,
    RK_ERR,
    RK_ARITH,
    RK_CMP
  } rkind_e;

  typedef struct packed {
    op_e    op;
    rsel_e  src_a;
    rsel_e  src_b;
    rsel_e  dst;
    rkind_e kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       func_bad;
    logic       den_zero;
    logic       bn_zero;
    logic       unit_done;
    logic       out_free;
  } dp_stat_t;

  localparam logic [4:0] PC_SUB = 5'd10;
  localparam logic [4:0] PC_ADD = 5'd11;
  localparam logic [4:0] PC_RED = 5'd18;
  localparam logic [4:0] PC_DIV = 5'd23;
  localparam logic [4:0] PC_MUL = 5'd25;
  localparam logic [4:0] PC_CMP = 5'd29;

  function automatic cmd_t mk(op_e op, rsel_e a = RS_AN, rsel_e b = RS_AN,
                              rsel_e d = RS_AN, rkind_e k = RK_NONE);
    cmd_t c;
    c.op    = op;
    c.src_a = a;
    c.src_b = b;
    c.dst   = d;
    c.kind  = k;
    return c;
  endfunction

  function automatic cmd_t ucode(logic [4:0] pc);
    cmd_t c;
    c = mk(OP_NOP);
    case (pc)
      5'd0:  c = mk(OP_CHK);
      5'd1:  c = mk(OP_GCD, RS_AN, RS_AD);
      5'd2:  c = mk(OP_DIV, RS_AN, RS_AN, RS_AN);
      5'd3:  c = mk(OP_DIV, RS_AD, RS_AN, RS_AD);
      5'd4:  c = mk(OP_FIXA);
      5'd5:  c = mk(OP_GCD, RS_BN, RS_BD);
      5'd6:  c = mk(OP_DIV, RS_BN, RS_AN, RS_BN);
      5'd7:  c = mk(OP_DIV, RS_BD, RS_AN, RS_BD);
      5'd8:  c = mk(OP_FIXB);
      5'd9:  c = mk(OP_DISP);
      5'd10: c = mk(OP_NEGB);
      5'd11: c = mk(OP_GCD, RS_AD, RS_BD);
      5'd12: c = mk(OP_DIV, RS_AD, RS_AN, RS_T);
      5'd13: c = mk(OP_MUL, RS_BN, RS_T, RS_BN);
      5'd14: c = mk(OP_DIV, RS_BD, RS_AN, RS_T);
      5'd15: c = mk(OP_MUL, RS_AN, RS_T, RS_AN);
      5'd16: c = mk(OP_MUL, RS_AD, RS_T, RS_AD);
      5'd17: c = mk(OP_COMB);
      5'd18: c = mk(OP_GCD, RS_AN, RS_AD);
      5'd19: c = mk(OP_DIV, RS_AN, RS_AN, RS_AN);
      5'd20: c = mk(OP_DIV, RS_AD, RS_AN, RS_AD);
      5'd21: c = mk(OP_FIXA);
      5'd22: c = mk(OP_OUT, RS_AN, RS_AN, RS_AN, RK_ARITH);
      5'd23: c = mk(OP_CHKDIV);
      5'd24: c = mk(OP_SWAPB);
      5'd25: c = mk(OP_MUL, RS_AN, RS_BN, RS_AN);
      5'd26: c = mk(OP_MUL, RS_AD, RS_BD, RS_AD);
      5'd27: c = mk(OP_XSIGN);
      5'd28: c = mk(OP_JMP);
      5'd29: c = mk(OP_MUL, RS_AN, RS_BD, RS_T);
      5'd30: c = mk(OP_MUL, RS_BN, RS_AD, RS_G);
      5'd31: c = mk(OP_OUT, RS_AN, RS_AN, RS_AN, RK_CMP);
      default: c = mk(OP_NOP);
    endcase
    return c;
  endfunction

endpackage

@@ design/rational_number_alu.sv @@
// Exact arithmetic on two signed fractions, one beat in, one beat out.
// Input channel: in_valid_i/in_ready_o with func_i and the two operands
// a_num_i/a_den_i and b_num_i/b_den_i. Output channel: out_valid_o/out_ready_i
// with res_num_o, res_den_o, order_o and status_o.
// One item is worked at a time; in_ready_o is high only while the sequencer
// is idle, which it is again as soon as the result sits in the output register.
// The work from accept to out_valid_o is data dependent: each operand and
// every arithmetic result is reduced by a binary gcd unit taking one subtract
// or shift step per cycle, and then divided by a restoring divider. A zero
// denominator and unused codes finish at the check step, before any gcd or
// division; a zero divisor is found only after both operands are reduced.
// Reset clears the sequencer and the output valid; no result is pending.
// When the receiver stalls, the result holds in the output register; the next
// item may be taken meanwhile and its work stops before its result beat
// until the output register is free.
module rational_number_alu import rna_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] res_num_o,
  output logic [30:0]        res_den_o,
  output logic [1:0]         order_o,
  output logic [1:0]         status_o
);

  cmd_t     cmd;
  dp_stat_t stat;

  rna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rna_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .func_i      (func_i),
    .a_num_i     (a_num_i),
    .a_den_i     (a_den_i),
    .b_num_i     (b_num_i),
    .b_den_i     (b_den_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .order_o     (order_o),
    .status_o    (status_o)
  );

endmodule

@@ design/rna_gcd.sv @@
module rna_gcd import rna_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  input  logic [63:0] y_i,
  output logic        done_o,
  output logic [63:0] g_o
);

  logic        busy_q, fin_q;
  logic [63:0] x_q, y_q;
  logic [5:0]  k_q;

  assign done_o = busy_q && fin_q && (k_q == 6'd0);
  assign g_o    = x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      fin_q  <= 1'b0;
    end else if (busy_q) begin
      if (fin_q) begin
        if (k_q == 6'd0) busy_q <= 1'b0;
      end else if (x_q == 64'd0 || y_q == 64'd0) begin
        fin_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      y_q <= y_i;
      k_q <= 6'd0;
    end else if (busy_q) begin
      if (fin_q) begin
        if (k_q != 6'd0) begin
          x_q <= {x_q[62:0], 1'b0};
          k_q <= k_q - 6'd1;
        end
      end else if (x_q == 64'd0 || y_q == 64'd0) begin
        x_q <= x_q | y_q;
      end else if (!x_q[0] && !y_q[0]) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + 6'd1;
      end else if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q >= y_q) begin
        x_q <= x_q - y_q;
      end else begin
        y_q <= y_q - x_q;
      end
    end
  end

endmodule

@@ design/rna_div.sv @@
module rna_div import rna_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] n_i,
  input  logic [63:0] d_i,
  output logic        done_o,
  output logic [63:0] q_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q, quo_q, d_q;
  logic [64:0] sh, diff;
  logic        ge;

  assign sh     = {rem_q, quo_q[63]};
  assign diff   = sh - {1'b0, d_q};
  assign ge     = sh >= {1'b0, d_q};
  assign done_o = busy_q && (cnt_q == 6'd0);
  assign q_o    = {quo_q[62:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd63;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd0) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 64'd0;
      quo_q <= n_i;
      d_q   <= d_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[63:0] : sh[63:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

endmodule

@@ design/rna_dp.sv @@
module rna_dp import rna_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output dp_stat_t           stat_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] res_num_o,
  output logic [30:0]        res_den_o,
  output logic [1:0]         order_o,
  output logic [1:0]         status_o
);

  localparam logic [63:0] Limit = 64'd1 << (WIDTH - 1);

  function automatic logic [63:0] mag32(logic [31:0] v);
    return v[31] ? 64'(33'h1_0000_0000 - {1'b0, v}) : 64'(v);
  endfunction

  logic [63:0] an_q, ad_q, bn_q, bd_q, t_q, g_q;
  logic        aneg_q, bneg_q;
  logic [2:0]  func_q;
  rsel_e       div_dst_q;

  logic [63:0] opa, opb, prod, wr_data;
  logic        wr_en;
  rsel_e       wr_sel;
  logic        g_done, d_done;
  logic [63:0] g_val, d_val;

  logic               out_valid_q;
  logic signed [31:0] res_num_q;
  logic [30:0]        res_den_q;
  logic [1:0]         order_q, status_q;
  logic signed [31:0] res_num_d;
  logic [30:0]        res_den_d;
  logic [1:0]         order_d, status_d;
  logic               ovf;

  always_comb begin
    case (cmd_i.src_a)
      RS_AN:   opa = an_q;
      RS_AD:   opa = ad_q;
      RS_BN:   opa = bn_q;
      RS_BD:   opa = bd_q;
      RS_T:    opa = t_q;
      default: opa = g_q;
    endcase
    case (cmd_i.src_b)
      RS_AN:   opb = an_q;
      RS_AD:   opb = ad_q;
      RS_BN:   opb = bn_q;
      RS_BD:   opb = bd_q;
      RS_T:    opb = t_q;
      default: opb = g_q;
    endcase
  end

  assign prod = opa[31:0] * opb[31:0];

  rna_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_GCD),
    .x_i     (opa),
    .y_i     (opb),
    .done_o  (g_done),
    .g_o     (g_val)
  );

  rna_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_DIV),
    .n_i     (opa),
    .d_i     (g_q),
    .done_o  (d_done),
    .q_o     (d_val)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_sel  = RS_G;
    wr_data = g_val;
    if (cmd_i.op == OP_MUL) begin
      wr_en   = 1'b1;
      wr_sel  = cmd_i.dst;
      wr_data = prod;
    end else if (d_done) begin
      wr_en   = 1'b1;
      wr_sel  = div_dst_q;
      wr_data = d_val;
    end else if (g_done) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      an_q   <= mag32(a_num_i);
      ad_q   <= mag32(a_den_i);
      bn_q   <= mag32(b_num_i);
      bd_q   <= mag32(b_den_i);
      aneg_q <= a_num_i[31] ^ a_den_i[31];
      bneg_q <= b_num_i[31] ^ b_den_i[31];
      func_q <= func_i;
    end else begin
      if (cmd_i.op == OP_DIV) div_dst_q <= cmd_i.dst;
      if (wr_en) begin
        case (wr_sel)
          RS_AN:   an_q <= wr_data;
          RS_AD:   ad_q <= wr_data;
          RS_BN:   bn_q <= wr_data;
          RS_BD:   bd_q <= wr_data;
          RS_T:    t_q  <= wr_data;
          default: g_q  <= wr_data;
        endcase
      end
      case (cmd_i.op)
        OP_FIXA: begin
          if (an_q == 64'd0) begin
            aneg_q <= 1'b0;
            ad_q   <= 64'd1;
          end
        end
        OP_FIXB: begin
          if (bn_q == 64'd0) begin
            bneg_q <= 1'b0;
            bd_q   <= 64'd1;
          end
        end
        OP_NEGB: begin
          if (bn_q != 64'd0) bneg_q <= ~bneg_q;
        end
        OP_SWAPB: begin
          bn_q <= bd_q;
          bd_q <= bn_q;
        end
        OP_COMB: begin
          if (aneg_q == bneg_q) begin
            an_q <= an_q + bn_q;
          end else if (an_q >= bn_q) begin
            an_q <= an_q - bn_q;
          end else begin
            an_q   <= bn_q - an_q;
            aneg_q <= bneg_q;
          end
        end
        OP_XSIGN: aneg_q <= aneg_q ^ bneg_q;
        default: ;
      endcase
    end
  end

  assign ovf = (ad_q > Limit - 64'd1) || (an_q > (aneg_q ? Limit : Limit - 64'd1));

  always_comb begin
    res_num_d = '0;
    res_den_d = '0;
    order_d   = ORD_EQ;
    status_d  = ST_OK;
    case (cmd_i.kind)
      RK_ERR: status_d = ST_ZERO;
      RK_ARITH: begin
        if (ovf) begin
          status_d = ST_OVF;
        end else begin
          res_num_d = aneg_q ? (~an_q[31:0] + 32'd1) : an_q[31:0];
          res_den_d = ad_q[30:0];
        end
      end
      RK_CMP: begin
        if (aneg_q != bneg_q) begin
          order_d = aneg_q ? ORD_LESS : ORD_GT;
        end else if (t_q == g_q) begin
          order_d = ORD_EQ;
        end else if (aneg_q) begin
          order_d = (t_q > g_q) ? ORD_LESS : ORD_GT;
        end else begin
          order_d = (t_q < g_q) ? ORD_LESS : ORD_GT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_RES) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RES) begin
      res_num_q <= res_num_d;
      res_den_q <= res_den_d;
      order_q   <= order_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign order_o     = order_q;
  assign status_o    = status_q;

  assign stat_o.func      = func_q;
  assign stat_o.func_bad  = func_q > FN_CMP;
  assign stat_o.den_zero  = (ad_q == 64'd0) || (bd_q == 64'd0);
  assign stat_o.bn_zero   = bn_q == 64'd0;
  assign stat_o.unit_done = g_done || d_done;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

@@ design/rna_ctrl.sv @@
module rna_ctrl import rna_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_RES   = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] pc_q, pc_d;
  rkind_e     kind_q, kind_d;
  cmd_t       u;

  assign u = ucode(pc_q);

  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    kind_d     = kind_q;
    in_ready_o = 1'b0;
    cmd_o      = mk(OP_NOP);
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = mk(OP_LOAD);
          pc_d    = 5'd0;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        case (u.op)
          OP_CHK: begin
            if (stat_i.func_bad) begin
              kind_d  = RK_NONE;
              state_d = S_RES;
            end else if (stat_i.den_zero) begin
              kind_d  = RK_ERR;
              state_d = S_RES;
            end else begin
              pc_d = pc_q + 5'd1;
            end
          end
          OP_DISP: begin
            case (stat_i.func)
              FN_ADD:  pc_d = PC_ADD;
              FN_SUB:  pc_d = PC_SUB;
              FN_MUL:  pc_d = PC_MUL;
              FN_DIV:  pc_d = PC_DIV;
              default: pc_d = PC_CMP;
            endcase
          end
          OP_CHKDIV: begin
            if (stat_i.bn_zero) begin
              kind_d  = RK_ERR;
              state_d = S_RES;
            end else begin
              pc_d = pc_q + 5'd1;
            end
          end
          OP_JMP: pc_d = PC_RED;
          OP_OUT: begin
            kind_d  = u.kind;
            state_d = S_RES;
          end
          OP_GCD, OP_DIV: begin
            cmd_o   = u;
            pc_d    = pc_q + 5'd1;
            state_d = S_WAIT;
          end
          default: begin
            cmd_o = u;
            pc_d  = pc_q + 5'd1;
          end
        endcase
      end
      S_WAIT: begin
        if (stat_i.unit_done) state_d = S_ISSUE;
      end
      S_RES: begin
        if (stat_i.out_free) begin
          cmd_o   = mk(OP_RES, RS_AN, RS_AN, RS_AN, kind_q);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= 5'd0;
      kind_q  <= RK_NONE;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      kind_q  <= kind_d;
    end
  end

endmodule

@@ design/rna_chk.sv @@
module rna_chk import rna_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] res_num_o,
  input logic [30:0]        res_den_o,
  input logic [1:0]         order_o,
  input logic [1:0]         status_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_num_o)
      && $stable(res_den_o) && $stable(order_o) && $stable(status_o))
    else $error("result beat dropped or changed under stall");

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a beat is in work");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> res_num_o == 32'sd0
      && res_den_o == 31'd0 && order_o == ORD_EQ)
    else $error("error beat carries a value");

  a_cmp_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && order_o != ORD_EQ |-> status_o == ST_OK
      && res_den_o == 31'd0 && res_num_o == 32'sd0)
    else $error("order reported on a non-compare beat");

  a_den_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_den_o == 31'd0 |-> res_num_o == 32'sd0)
    else $error("numerator without denominator");

endmodule

bind rational_number_alu rna_chk u_rna_chk (.*);

@@ verif/rna_checker.sv @@
module rna_checker import rna_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] res_num_i,
  input  logic [30:0]        res_den_i,
  input  logic [1:0]         order_i,
  input  logic [1:0]         status_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIDTH = 32;

  typedef struct {
    bit        neg;
    bit [63:0] num;
    bit [63:0] den;
  } fraction_t;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    order_e      ord;
    status_e     st;
  } alu_result_t;

  alu_result_t results_q[$];

  function automatic bit [63:0] gcd64(bit [63:0] x, bit [63:0] y);
    bit [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t reduce(fraction_t f);
    bit [63:0] g;
    g = gcd64(f.num, f.den);
    if (g != 0) begin
      f.num = f.num / g;
      f.den = f.den / g;
    end
    if (f.num == 0) begin
      f.neg = 1'b0;
      f.den = 1;
    end
    return f;
  endfunction

  function automatic bit [63:0] magnitude(logic [31:0] v);
    return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
  endfunction

  function automatic fraction_t normalize(logic [31:0] n, logic [31:0] d);
    fraction_t f;
    f.num = magnitude(n);
    f.den = magnitude(d);
    f.neg = n[31] != d[31];
    return (f.den == 0) ? f : reduce(f);
  endfunction

  function automatic fraction_t frac_sum(fraction_t a, fraction_t b);
    fraction_t r;
    bit [63:0] l, ta, tb;
    l  = (a.den / gcd64(a.den, b.den)) * b.den;
    ta = a.num * (l / a.den);
    tb = b.num * (l / b.den);
    if (a.neg == b.neg) begin
      r.neg = a.neg;
      r.num = ta + tb;
    end else if (ta >= tb) begin
      r.neg = a.neg;
      r.num = ta - tb;
    end else begin
      r.neg = b.neg;
      r.num = tb - ta;
    end
    r.den = l;
    return reduce(r);
  endfunction

  function automatic fraction_t frac_prod(fraction_t a, fraction_t b);
    fraction_t r;
    r.neg = a.neg != b.neg;
    r.num = a.num * b.num;
    r.den = a.den * b.den;
    return reduce(r);
  endfunction

  function automatic order_e frac_order(fraction_t a, fraction_t b);
    bit [63:0] l, r;
    l = a.num * b.den;
    r = b.num * a.den;
    if (a.neg != b.neg) return a.neg ? ORD_LESS : ORD_GT;
    if (l == r) return ORD_EQ;
    if (a.neg) return (l > r) ? ORD_LESS : ORD_GT;
    return (l < r) ? ORD_LESS : ORD_GT;
  endfunction

  function automatic alu_result_t compute(logic [2:0] fn, logic [31:0] an, logic [31:0] ad,
                                          logic [31:0] bn, logic [31:0] bd);
    alu_result_t res;
    fraction_t a, b, r, inv;
    bit [63:0] lim;
    lim = 64'd1 << (WIDTH - 1);
    res = '{num: '0, den: '0, ord: ORD_EQ, st: ST_OK};
    if (fn > FN_CMP) return res;
    a = normalize(an, ad);
    b = normalize(bn, bd);
    if (a.den == 0 || b.den == 0) begin
      res.st = ST_ZERO;
      return res;
    end
    case (func_e'(fn))
      FN_ADD: r = frac_sum(a, b);
      FN_SUB: begin
        if (b.num != 0) b.neg = !b.neg;
        r = frac_sum(a, b);
      end
      FN_MUL: r = frac_prod(a, b);
      FN_DIV: begin
        if (b.num == 0) begin
          res.st = ST_ZERO;
          return res;
        end
        inv.neg = b.neg;
        inv.num = b.den;
        inv.den = b.num;
        r = frac_prod(a, inv);
      end
      default: begin
        res.ord = frac_order(a, b);
        return res;
      end
    endcase
    if (r.den > lim - 1 || r.num > (r.neg ? lim : lim - 1)) begin
      res.st = ST_OVF;
      return res;
    end
    res.num = r.neg ? 32'(64'd0 - r.num) : r.num[31:0];
    res.den = r.den[30:0];
    return res;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  // Sample at the falling edge: handshake signals are stable until the next rising edge.
  always @(negedge clk_i) begin
    alu_result_t w;
    if (rst_ni && in_valid_i && in_ready_i) begin
      results_q.push_back(compute(func_i, a_num_i, a_den_i, b_num_i, b_den_i));
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (results_q.size() == 0) begin
        report("unexpected beat", 64'(res_num_i), '0);
      end else begin
        w = results_q.pop_front();
        if (res_num_i !== w.num) report("res_num", res_num_i, w.num);
        if (res_den_i !== w.den) report("res_den", res_den_i, w.den);
        if (order_i !== w.ord) report("order", order_i, w.ord);
        if (status_i !== w.st) report("status", status_i, w.st);
      end
    end
    pending_o = results_q.size();
  end
endmodule

@@ verif/rational_number_alu_tb.sv @@
module rational_number_alu_tb import rna_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 480;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         func;
  logic signed [31:0] a_num, a_den, b_num, b_den;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic [1:0]         order;
  logic [1:0]         status;
  int                 errors;
  int                 pending;
  bit                 in_beat;
  int                 idle_cycles;
  int                 beats_sent;
  int                 burst_left;

  rational_number_alu i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .func_i      (func),
    .a_num_i     (a_num),
    .a_den_i     (a_den),
    .b_num_i     (b_num),
    .b_den_i     (b_den),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .res_num_o   (res_num),
    .res_den_o   (res_den),
    .order_o     (order),
    .status_o    (status)
  );

  rna_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .func_i      (func),
    .a_num_i     (a_num),
    .a_den_i     (a_den),
    .b_num_i     (b_num),
    .b_den_i     (b_den),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .res_num_i   (res_num),
    .res_den_i   (res_den),
    .order_i     (order),
    .status_i    (status),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    in_beat = in_valid && in_ready;
    if (in_beat || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else if (rst_n) begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("FAIL rational_number_alu");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 40)) - 20);
      1: return 32'($signed($urandom_range(0, 131070)) - 65535);
      2: case ($urandom_range(0, 4))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0000_0001;
           3: return 32'hffff_ffff;
           default: return 32'h8000_0001;
         endcase
      3: return 32'($urandom_range(1, 12)) << $urandom_range(0, 30);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [2:0] fn, logic [31:0] an, logic [31:0] ad,
                      logic [31:0] bn, logic [31:0] bd);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    func     <= fn;
    a_num    <= an;
    a_den    <= ad;
    b_num    <= bn;
    b_den    <= bd;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_beat);
    burst_left--;
    beats_sent++;
  endtask

  initial begin
    bit held;
    int mode;
    held = 1'b0;
    out_ready = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (!held && beats_sent >= 150) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        held = 1'b1;
      end else begin
        if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    func        = '0;
    a_num       = '0;
    a_den       = '0;
    b_num       = '0;
    b_den       = '0;
    idle_cycles = 0;
    beats_sent  = 0;
    burst_left  = 4;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(FN_ADD, 1, 2, 1, 3);
    send(FN_SUB, 1, 2, 1, 2);
    send(FN_MUL, -3, 4, 8, -9);
    send(FN_DIV, 2, 3, -4, 5);
    send(FN_CMP, 1, 3, 2, 6);
    send(FN_CMP, -1, 2, 1, 3);
    send(FN_CMP, 5, 7, 2, 3);
    send(FN_ADD, 1, 0, 1, 1);
    send(FN_MUL, 1, 1, 1, 0);
    send(FN_DIV, 3, 4, 0, 5);
    send(FN_ADD, mn, 1, mn, 1);
    send(FN_MUL, mn, 1, -1, 1);
    send(FN_DIV, mn, -1, 1, 1);
    send(FN_MUL, mx, 1, mx, 1);
    send(FN_ADD, 1, mx, 1, mx - 1);
    send(FN_SUB, mn, mn, mx, mx);
    send(FN_CMP, mn, 1, mx, 1);
    send(FN_CMP, mn, mx, mn, mx);
    send(FN_SUB, 0, -7, 0, 5);
    send(3'd5, 1, 2, 3, 4);
    send(3'd6, 0, 0, 0, 0);
    send(3'd7, mn, mx, mn, mx);
    send(FN_DIV, 1, mn, mn, 1);

    for (int i = 0; i < N_RANDOM; i++) begin
      send(($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
           pick_value(), pick_value(), pick_value(), pick_value());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (errors == 0) begin
      $display("PASS rational_number_alu");
    end else begin
      $display("FAIL rational_number_alu");
    end
    $finish;
  end
endmodule

@@ files.f @@
design/rna_pkg.sv
design/rna_gcd.sv
design/rna_div.sv
design/rna_dp.sv
design/rna_ctrl.sv
design/rational_number_alu.sv
design/rna_chk.sv
verif/rna_checker.sv
verif/rational_number_alu_tb.sv
